// File: design/srde_pkg.sv
package srde_pkg;

  // channel and run limits
  localparam int NUM_CHANNELS  = 2;
  localparam int CH_W          = 1;
  localparam int MAX_RUN_TICKS = 256;
  localparam int RUN_W         = 9;

  // record shape
  localparam int REC_BYTES = 8;
  localparam int BIDX_W    = 3;
  localparam int CNT_W     = 4;

  // record queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // stream widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  // record opcodes and control byte flags
  localparam logic [7:0] SYNC_OP   = 8'h3E;
  localparam logic [7:0] LWAIT_OP  = 8'h3F;
  localparam logic [7:0] STEP_OP   = 8'h40;
  localparam logic [7:0] ABS_OP    = 8'h60;
  localparam logic [7:0] CTRL_OP   = 8'h80;
  localparam logic [7:0] CTRL_VOL  = 8'h40;
  localparam logic [7:0] CTRL_INS  = 8'h20;
  localparam logic [7:0] CTRL_WAIT = 8'h10;

  // waits from this value up take the long form
  localparam logic [RUN_W-1:0] LONG_WAIT_MIN = 9'd17;

  // input item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // one encoded record, bytes in send order from index 0
  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          nbytes;
    logic [CH_W-1:0]           channel;
    logic [RUN_W-1:0]          ticks;
  } rec_t;

endpackage

// File: design/srde_front.sv
module srde_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [srde_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  output logic                              rec_valid,
  output srde_pkg::rec_t                    rec,
  input  logic                              rec_ready
);
  import srde_pkg::*;

  // per-channel state
  logic [12:0]      prior_pitch_r [NUM_CHANNELS];
  logic [3:0]       prior_ins_r   [NUM_CHANNELS];
  logic [3:0]       prior_vol_r   [NUM_CHANNELS];
  logic             forced_r      [NUM_CHANNELS];
  logic             sync_v_r      [NUM_CHANNELS];
  logic [7:0]       sync_r        [NUM_CHANNELS];
  logic             step_v_r      [NUM_CHANNELS];
  logic [4:0]       step_r        [NUM_CHANNELS];
  logic             abs_v_r       [NUM_CHANNELS];
  logic [12:0]      abs_r         [NUM_CHANNELS];
  logic             ins_v_r       [NUM_CHANNELS];
  logic [3:0]       ins_r         [NUM_CHANNELS];
  logic [3:0]       vd_r          [NUM_CHANNELS];
  logic [RUN_W-1:0] run_r         [NUM_CHANNELS];
  logic [RUN_W-1:0] prev_wait_r   [NUM_CHANNELS];

  // field decode
  logic            accept;
  logic            kind;
  logic [CH_W-1:0] ch;
  logic            pitch_valid;
  logic [12:0]     pitch_value;
  logic            instrument_valid;
  logic [3:0]      instrument;
  logic            volume_valid;
  logic [3:0]      volume;
  logic            sync_valid;
  logic [7:0]      sync_value;

  assign in_tready        = rec_ready;
  assign accept           = in_tvalid & in_tready;
  assign kind             = in_tuser;
  assign ch               = in_tdata[0];
  assign pitch_valid      = in_tdata[1];
  assign pitch_value      = in_tdata[14:2];
  assign instrument_valid = in_tdata[15];
  assign instrument       = in_tdata[19:16];
  assign volume_valid     = in_tdata[20];
  assign volume           = in_tdata[24:21];
  assign sync_valid       = in_tdata[25];
  assign sync_value       = in_tdata[33:26];

  // change detection against the channel's last values
  logic               pitch_chg, ins_chg, vol_chg, has_cmd;
  logic signed [13:0] dt, dt_neg, dt_pos;
  logic               near;
  logic [4:0]         new_step;
  logic [3:0]         new_vd;

  assign pitch_chg = pitch_valid & (forced_r[ch] | (pitch_value != prior_pitch_r[ch]));
  assign ins_chg   = instrument_valid & (instrument != prior_ins_r[ch]);
  assign vol_chg   = volume_valid & (volume != prior_vol_r[ch]);
  assign has_cmd   = pitch_chg | ins_chg | vol_chg | sync_valid;

  assign dt       = $signed({1'b0, pitch_value}) - $signed({1'b0, prior_pitch_r[ch]});
  assign dt_neg   = 14'sd15 - dt;
  assign dt_pos   = dt - 14'sd1;
  assign near     = ~forced_r[ch] & (dt >= -14'sd16) & (dt <= 14'sd16);
  assign new_step = dt[13] ? dt_neg[4:0] : dt_pos[4:0];
  assign new_vd   = volume - prior_vol_r[ch];

  // flush selection: end item, new command, or run cap
  logic [RUN_W-1:0] run_inc, ticks_f;
  logic             cap, do_flush, push;

  assign run_inc  = run_r[ch] + 9'd1;
  assign cap      = (kind == KIND_TICK) & ~has_cmd & (run_inc >= RUN_W'(MAX_RUN_TICKS));
  assign ticks_f  = cap ? run_inc : run_r[ch];
  assign do_flush = (kind == KIND_END) | has_cmd | cap;
  assign push     = accept & do_flush & (ticks_f != '0);

  // record assembly from the pending command
  logic             wait_chg, long_wait, short_wait;
  logic [RUN_W-1:0] wm1;
  logic [7:0]       c1, c2;
  logic [1:0]       vlen;
  logic [CNT_W-1:0] idx;
  logic [REC_BYTES-1:0][7:0] bytes;

  assign wait_chg   = prev_wait_r[ch] != ticks_f;
  assign long_wait  = wait_chg & (ticks_f >= LONG_WAIT_MIN);
  assign short_wait = wait_chg & (ticks_f < LONG_WAIT_MIN);
  assign wm1        = ticks_f - 9'd1;

  always_comb begin
    bytes = '0;
    idx   = '0;
    c1    = CTRL_OP;
    c2    = '0;
    vlen  = '0;
    if (sync_v_r[ch]) begin
      bytes[idx[BIDX_W-1:0]]         = SYNC_OP;
      bytes[idx[BIDX_W-1:0] + 3'd1]  = sync_r[ch];
      idx = idx + 4'd2;
    end
    if (long_wait) begin
      bytes[idx[BIDX_W-1:0]]         = LWAIT_OP;
      bytes[idx[BIDX_W-1:0] + 3'd1]  = wm1[7:0];
      idx = idx + 4'd2;
    end
    if (step_v_r[ch]) begin
      bytes[idx[BIDX_W-1:0]] = STEP_OP | {3'b000, step_r[ch]};
      idx = idx + 4'd1;
    end
    if (abs_v_r[ch]) begin
      bytes[idx[BIDX_W-1:0]]         = ABS_OP | {3'b000, abs_r[ch][12:8]};
      bytes[idx[BIDX_W-1:0] + 3'd1]  = abs_r[ch][7:0];
      idx = idx + 4'd2;
    end
    // control byte nibbles fill c1 first, overflow goes to c2
    if (vd_r[ch] != '0) begin
      c1   = c1 | CTRL_VOL | {4'h0, vd_r[ch]};
      vlen = 2'd1;
    end
    if (ins_v_r[ch]) begin
      c1 = c1 | CTRL_INS;
      if (vlen == 2'd0) c1 = c1 | {4'h0, ins_r[ch]};
      else              c2 = {4'h0, ins_r[ch]};
      vlen = vlen + 2'd1;
    end
    if (short_wait) begin
      c1 = c1 | CTRL_WAIT;
      if (vlen == 2'd0)      c1 = c1 | {4'h0, wm1[3:0]};
      else if (vlen == 2'd1) c2 = {4'h0, wm1[3:0]};
      else                   c2 = c2 | {wm1[3:0], 4'h0};
      vlen = vlen + 2'd1;
    end
    bytes[idx[BIDX_W-1:0]] = c1;
    idx = idx + 4'd1;
    if (vlen >= 2'd2) begin
      bytes[idx[BIDX_W-1:0]] = c2;
      idx = idx + 4'd1;
    end
  end

  assign rec_valid   = push;
  assign rec.bytes   = bytes;
  assign rec.nbytes  = idx;
  assign rec.channel = ch;
  assign rec.ticks   = ticks_f;

  // state update for the addressed channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        prior_pitch_r[i] <= '0;
        prior_ins_r[i]   <= '0;
        prior_vol_r[i]   <= '0;
        forced_r[i]      <= 1'b1;
        sync_v_r[i]      <= 1'b0;
        sync_r[i]        <= '0;
        step_v_r[i]      <= 1'b0;
        step_r[i]        <= '0;
        abs_v_r[i]       <= 1'b0;
        abs_r[i]         <= '0;
        ins_v_r[i]       <= 1'b0;
        ins_r[i]         <= '0;
        vd_r[i]          <= '0;
        run_r[i]         <= '0;
        prev_wait_r[i]   <= '0;
      end
    end else if (accept) begin
      if (ticks_f != '0 && do_flush) begin
        prev_wait_r[ch] <= ticks_f;
      end
      if (kind == KIND_END || cap) begin
        sync_v_r[ch] <= 1'b0;
        step_v_r[ch] <= 1'b0;
        abs_v_r[ch]  <= 1'b0;
        ins_v_r[ch]  <= 1'b0;
        vd_r[ch]     <= '0;
        run_r[ch]    <= '0;
      end else if (has_cmd) begin
        sync_v_r[ch] <= sync_valid;
        sync_r[ch]   <= sync_value;
        step_v_r[ch] <= pitch_chg & near;
        step_r[ch]   <= new_step;
        abs_v_r[ch]  <= pitch_chg & ~near;
        abs_r[ch]    <= pitch_value;
        ins_v_r[ch]  <= ins_chg;
        ins_r[ch]    <= instrument;
        vd_r[ch]     <= vol_chg ? new_vd : 4'h0;
        run_r[ch]    <= 9'd1;
        if (pitch_chg) begin
          prior_pitch_r[ch] <= pitch_value;
          forced_r[ch]      <= 1'b0;
        end
        if (ins_chg) prior_ins_r[ch] <= instrument;
        if (vol_chg) prior_vol_r[ch] <= volume;
      end else begin
        run_r[ch] <= run_inc;
      end
    end
  end

endmodule

// File: design/srde_queue.sv
module srde_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  srde_pkg::rec_t push_rec,
  output logic           has_room,
  input  logic           pop,
  output logic           not_empty,
  output srde_pkg::rec_t head
);
  import srde_pkg::*;

  rec_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign has_room  = count_r != QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = slot_r[rd_ptr_r];
  assign do_pop    = pop & not_empty;

  // record storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop)      count_r <= count_r + QCNT_W'(1);
      else if (!push && do_pop) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// File: design/srde_back.sv
module srde_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  srde_pkg::rec_t                  head,
  output logic                            head_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srde_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast
);
  import srde_pkg::*;

  logic [BIDX_W-1:0] idx_r;
  logic              beat;
  logic              last;

  assign last       = {1'b0, idx_r} == (head.nbytes - 4'd1);
  assign out_tvalid = head_valid;
  assign out_tdata  = {6'b0, head.ticks, head.channel, head.bytes[idx_r]};
  assign out_tlast  = last;
  assign beat       = out_tvalid & out_tready;
  assign head_pop   = beat & last;

  // byte index within the record at the queue head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (beat) begin
      idx_r <= last ? '0 : idx_r + 3'd1;
    end
  end

endmodule

// File: design/sound_register_delta_encoder.sv
// a flushing item's record is written into the queue at the clock edge that accepts the item; its first
// byte is offered from the queue head once the records ahead of it are sent
// throughput: one item per cycle while the two-record queue has room; the byte serializer sends one byte per cycle
// while out_tready is high, and a record holds 1 to 8 bytes
// reset: synchronous active-low; clears all channel state, the queue and the byte index; no clearing pass
module sound_register_delta_encoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // channel, pitch_valid, pitch_value[13], instrument_valid, instrument[4],
  // volume_valid, volume[4], sync_valid, sync_value[8], zero pad
  input  logic [srde_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_byte[8], out_channel, chunk_ticks[9], zero pad
  output logic [srde_pkg::OUT_DATA_W-1:0] out_tdata,
  // last_byte
  output logic                            out_tlast
);
  import srde_pkg::*;

  logic rec_valid, has_room, not_empty, head_pop;
  rec_t rec, head;

  srde_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (has_room)
  );

  srde_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rec_valid),
    .push_rec  (rec),
    .has_room  (has_room),
    .pop       (head_pop),
    .not_empty (not_empty),
    .head      (head)
  );

  srde_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (not_empty),
    .head       (head),
    .head_pop   (head_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/tb_sound_register_delta_encoder.sv
`timescale 1ns / 100ps

module tb_sound_register_delta_encoder;
  import srde_pkg::*;

  // one record byte as it leaves the encoder
  typedef struct packed {
    logic [7:0]       code;
    logic             chan;
    logic [RUN_W-1:0] ticks;
    logic             tail;
  } enc_byte_t;

  // per-channel change tracker and the record bytes still owed by the block
  class encoder_scoreboard;
    logic [12:0] last_pitch [NUM_CHANNELS];
    logic [3:0]  last_instr [NUM_CHANNELS];
    logic [3:0]  last_vol   [NUM_CHANNELS];
    bit          pitch_first[NUM_CHANNELS];
    bit          sync_held  [NUM_CHANNELS];
    logic [7:0]  sync_byte  [NUM_CHANNELS];
    bit          step_held  [NUM_CHANNELS];
    logic [4:0]  step_code  [NUM_CHANNELS];
    bit          abs_held   [NUM_CHANNELS];
    logic [12:0] abs_pitch  [NUM_CHANNELS];
    bit          instr_held [NUM_CHANNELS];
    logic [3:0]  instr_new  [NUM_CHANNELS];
    logic [3:0]  vol_step   [NUM_CHANNELS];
    int          run_ticks  [NUM_CHANNELS];
    int          last_wait  [NUM_CHANNELS];
    enc_byte_t   owed[$];
    int          errors;
    int          items;
    int          records;
    int          beats;

    function new();
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        last_pitch[c]  = '0;
        last_instr[c]  = '0;
        last_vol[c]    = '0;
        pitch_first[c] = 1'b1;
        sync_held[c]   = 1'b0;
        step_held[c]   = 1'b0;
        abs_held[c]    = 1'b0;
        instr_held[c]  = 1'b0;
        vol_step[c]    = '0;
        run_ticks[c]   = 0;
        last_wait[c]   = 0;
      end
      errors  = 0;
      items   = 0;
      records = 0;
      beats   = 0;
    endfunction

    // close the channel's pending command into a record, returns its byte count
    function automatic int close_record(int ch);
      logic [7:0] rec [8];
      logic [7:0] c1;
      logic [7:0] c2;
      logic [3:0] v;
      enc_byte_t  b;
      int         n;
      int         ticks;
      int         wait_n;
      int         nibs;
      ticks = run_ticks[ch];
      if (ticks == 0) return 0;
      n = 0;
      wait_n = 0;
      nibs = 0;
      c1 = CTRL_OP;
      c2 = 8'h00;
      // the wait goes out only when it differs from the last one sent
      if (last_wait[ch] != ticks) begin
        wait_n = ticks;
        last_wait[ch] = ticks;
      end
      if (sync_held[ch]) begin
        rec[n] = SYNC_OP;
        rec[n+1] = sync_byte[ch];
        n += 2;
      end
      if (wait_n >= LONG_WAIT_MIN) begin
        rec[n] = LWAIT_OP;
        rec[n+1] = 8'(wait_n - 1);
        n += 2;
      end
      if (step_held[ch]) begin
        rec[n] = STEP_OP | {3'b000, step_code[ch]};
        n += 1;
      end
      if (abs_held[ch]) begin
        rec[n] = ABS_OP | {3'b000, abs_pitch[ch][12:8]};
        rec[n+1] = abs_pitch[ch][7:0];
        n += 2;
      end
      // control byte nibbles fill the low nibble first, then spill over
      if (vol_step[ch] != 4'h0) begin
        c1 = c1 | CTRL_VOL | {4'h0, vol_step[ch]};
        nibs = 1;
      end
      if (instr_held[ch]) begin
        c1 = c1 | CTRL_INS;
        if (nibs == 0) c1 = c1 | {4'h0, instr_new[ch]};
        else c2 = {4'h0, instr_new[ch]};
        nibs++;
      end
      if (wait_n >= 1 && wait_n < LONG_WAIT_MIN) begin
        v = 4'(wait_n - 1);
        c1 = c1 | CTRL_WAIT;
        if (nibs == 0) c1 = c1 | {4'h0, v};
        else if (nibs == 1) c2 = {4'h0, v};
        else c2 = c2 | {v, 4'h0};
        nibs++;
      end
      rec[n] = c1;
      n += 1;
      if (nibs >= 2) begin
        rec[n] = c2;
        n += 1;
      end
      for (int k = 0; k < n; k++) begin
        b.code  = rec[k];
        b.chan  = 1'(ch);
        b.ticks = RUN_W'(ticks);
        b.tail  = (k == n - 1);
        owed = {owed, b};
      end
      sync_held[ch]  = 1'b0;
      step_held[ch]  = 1'b0;
      abs_held[ch]   = 1'b0;
      instr_held[ch] = 1'b0;
      vol_step[ch]   = '0;
      run_ticks[ch]  = 0;
      records++;
      return n;
    endfunction

    // accepted input beat: update the channel and queue any record bytes
    function automatic void note_item(logic kind, logic [IN_DATA_W-1:0] w);
      int          ch;
      int          n;
      int          dt;
      bit          changed;
      logic [12:0] p;
      logic [3:0]  iv;
      logic [3:0]  vv;
      bit          n_sync;
      bit          n_step;
      bit          n_abs;
      bit          n_ins;
      logic [7:0]  s_byte;
      logic [4:0]  s_code;
      logic [3:0]  v_step;
      ch = int'(w[0]);
      p  = w[14:2];
      iv = w[19:16];
      vv = w[24:21];
      n = 0;
      changed = 1'b0;
      n_sync = 1'b0;
      n_step = 1'b0;
      n_abs = 1'b0;
      n_ins = 1'b0;
      s_byte = w[33:26];
      s_code = '0;
      v_step = '0;
      items++;
      if (ch >= NUM_CHANNELS) return;
      if (kind == KIND_END) begin
        void'(close_record(ch));
        return;
      end
      // pitch: small moves become a step code, first pitch is always absolute
      if (w[1] && (pitch_first[ch] || p != last_pitch[ch])) begin
        dt = int'(p) - int'(last_pitch[ch]);
        if (!pitch_first[ch] && dt >= -16 && dt <= 16) begin
          n_step = 1'b1;
          s_code = (dt < 0) ? 5'(15 - dt) : 5'(dt - 1);
        end else begin
          n_abs = 1'b1;
        end
        last_pitch[ch] = p;
        pitch_first[ch] = 1'b0;
        changed = 1'b1;
      end
      if (w[15] && iv != last_instr[ch]) begin
        n_ins = 1'b1;
        last_instr[ch] = iv;
        changed = 1'b1;
      end
      if (w[20] && vv != last_vol[ch]) begin
        v_step = vv - last_vol[ch];
        last_vol[ch] = vv;
        changed = 1'b1;
      end
      if (w[25]) begin
        n_sync = 1'b1;
        changed = 1'b1;
      end
      // a new command closes the previous one and starts a fresh run
      if (changed) begin
        n = close_record(ch);
        sync_held[ch]  = n_sync;
        sync_byte[ch]  = s_byte;
        step_held[ch]  = n_step;
        step_code[ch]  = s_code;
        abs_held[ch]   = n_abs;
        abs_pitch[ch]  = p;
        instr_held[ch] = n_ins;
        instr_new[ch]  = iv;
        vol_step[ch]   = v_step;
        run_ticks[ch]  = 0;
      end
      run_ticks[ch]++;
      if (n == 0 && run_ticks[ch] >= MAX_RUN_TICKS) void'(close_record(ch));
    endfunction

    // accepted output beat against the oldest owed byte
    function automatic void check_byte(enc_byte_t got);
      enc_byte_t want;
      beats++;
      if (owed.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual byte %02h ch %0d ticks %0d last %0b",
                 $time, got.code, got.chan, got.ticks, got.tail);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.code !== want.code) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.code, got.code);
        errors++;
      end
      if (got.chan !== want.chan) begin
        $display("%0t: out_channel expected %0d actual %0d", $time, want.chan, got.chan);
        errors++;
      end
      if (got.ticks !== want.ticks) begin
        $display("%0t: chunk_ticks expected %0d actual %0d", $time, want.ticks, got.ticks);
        errors++;
      end
      if (got.tail !== want.tail) begin
        $display("%0t: last_byte expected %0b actual %0b", $time, want.tail, got.tail);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  encoder_scoreboard sb = new();
  bit in_burst;
  bit out_burst;

  sound_register_delta_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // input beat layout, channel in bit 0
  function automatic logic [IN_DATA_W-1:0] pack_item(logic ch, logic pv, logic [12:0] p,
                                                     logic iv, logic [3:0] ins,
                                                     logic vv, logic [3:0] vol,
                                                     logic sv, logic [7:0] s);
    return {6'b0, s, sv, vol, vv, ins, iv, p, pv, ch};
  endfunction

  // tick with random content, density sets how often each field is written
  function automatic logic [IN_DATA_W-1:0] make_tick(logic ch, int density);
    logic [12:0] p;
    logic [3:0]  ins;
    logic [3:0]  vol;
    int          r;
    r = $urandom_range(99);
    if (r < 40) p = sb.last_pitch[ch] + 13'($urandom_range(32)) - 13'd16;
    else if (r < 55) p = sb.last_pitch[ch];
    else p = 13'($urandom);
    ins = $urandom_range(1) ? sb.last_instr[ch] : 4'($urandom);
    vol = $urandom_range(1) ? sb.last_vol[ch] : 4'($urandom);
    return pack_item(ch, $urandom_range(99) < density, p,
                     $urandom_range(99) < density, ins,
                     $urandom_range(99) < density, vol,
                     $urandom_range(99) < density / 4, 8'($urandom));
  endfunction

  // tick that writes nothing, value fields are noise
  function automatic logic [IN_DATA_W-1:0] quiet_tick(logic ch);
    return pack_item(ch, 1'b0, 13'($urandom), 1'b0, 4'($urandom), 1'b0, 4'($urandom),
                     1'b0, 8'($urandom));
  endfunction

  // drive one input beat, entered and left at a falling edge with valid held
  task automatic put_item(input logic kind, input logic [IN_DATA_W-1:0] w);
    int gap;
    if ($urandom_range(39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, w);
    @(negedge clk);
  endtask

  task automatic put_end(input logic ch);
    put_item(KIND_END, {6'b0, 1'($urandom_range(1)), 32'($urandom), ch});
  endtask

  // result sink with random stalls
  initial begin : sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(39) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte('{out_tdata[7:0], out_tdata[8], out_tdata[17:9], out_tlast});
  end

  // stimulus
  initial begin
    int density;
    logic ch;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_TICK;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // first pitch is absolute even when it matches the reset value
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd0, 1'b1, 4'hF, 1'b1, 4'hF, 1'b1, 8'hFF));
    // step extremes both ways
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd16, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 8'h00));
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 8'h00));
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd1, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 8'h00));
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 8'h00));
    put_item(KIND_TICK, quiet_tick(1'b0));
    put_item(KIND_TICK, quiet_tick(1'b0));
    // just past step range, plus volume and instrument so nibbles spill
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd17, 1'b1, 4'h0, 1'b1, 4'h0, 1'b0, 8'h00));
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd8191, 1'b0, 4'h0, 1'b1, 4'hF, 1'b0, 8'h00));
    // second channel, sync there too
    put_item(KIND_TICK, pack_item(1'b1, 1'b1, 13'd8191, 1'b1, 4'h9, 1'b0, 4'h0, 1'b1, 8'h00));
    // same values written again: no new command
    put_item(KIND_TICK, pack_item(1'b1, 1'b1, 13'd8191, 1'b1, 4'h9, 1'b1, 4'h0, 1'b0, 8'h00));
    put_item(KIND_END, {6'b0, {33{1'b1}}, 1'b1});
    // nothing pending: end emits nothing
    put_end(1'b1);
    put_item(KIND_TICK, pack_item(1'b1, 1'b0, 13'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b1, 8'h5A));
    put_item(KIND_TICK, pack_item(1'b1, 1'b1, 13'd0, 1'b0, 4'h0, 1'b0, 4'h0, 1'b0, 8'h00));
    put_end(1'b0);
    put_item(KIND_TICK, quiet_tick(1'b0));
    put_end(1'b0);
    put_item(KIND_TICK, pack_item(1'b0, 1'b1, 13'd8175, 1'b1, 4'h5, 1'b1, 4'h7, 1'b1, 8'hA5));
    put_end(1'b1);

    // random phrases with changing density
    density = 50;
    for (int i = 0; i < 24; i++) begin
      if (i % 8 == 0) begin
        case ($urandom_range(2))
          0: density = 10;
          1: density = 50;
          default: density = 90;
        endcase
      end
      ch = 1'($urandom_range(1));
      if ($urandom_range(99) < 3) put_end(ch);
      else put_item(KIND_TICK, make_tick(ch, density));
    end

    // long quiet run on channel 1 to hit the run cap
    put_item(KIND_TICK, pack_item(1'b1, 1'b0, 13'd0, 1'b0, 4'h0, 1'b0, 4'h0,
                                  1'b1, 8'($urandom)));
    for (int i = 0; i < 258; i++) begin
      put_item(KIND_TICK, quiet_tick(1'b1));
      if ($urandom_range(11) == 0) put_item(KIND_TICK, make_tick(1'b0, 50));
    end
    put_end(1'b0);
    put_end(1'b1);
    in_tvalid <= 1'b0;

    // drain
    while (sb.owed.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.owed.size() > 0) begin
      $display("%0t: %0d expected bytes never arrived, first expected %02h",
               $time, sb.owed.size(), sb.owed[0].code);
      sb.errors += sb.owed.size();
    end

    $display("run covered %0d input beats, %0d records, %0d output beats checked",
             sb.items, sb.records, sb.beats);
    $display("mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/srde_pkg.sv
design/srde_front.sv
design/srde_queue.sv
design/srde_back.sv
design/sound_register_delta_encoder.sv
tb/tb_sound_register_delta_encoder.sv
